FILE: hw/rtl/mp2a_pkg.sv
package mp2a_pkg;

  localparam int MAX_WIDTH     = 256;
  localparam int MAX_KERNEL    = 8;
  localparam int MAX_HEIGHT    = 256;
  localparam int SAMPLE_BITS   = 16;
  localparam int POS_BITS      = 8;
  localparam int KERNEL_BITS   = 4;
  localparam int STRIDE_BITS   = 4;
  localparam int DIM_BITS      = 9;
  localparam int CFG_BITS      = 9;
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int SLOT_BITS     = $clog2(MAX_KERNEL);
  localparam int KIDX_BITS     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int STORE_DEPTH   = MAX_KERNEL * MAX_WIDTH;
  localparam int ADDR_BITS     = SLOT_BITS + COL_BITS;

  typedef enum logic [1:0] {
    REG_KERNEL = 2'd0,
    REG_STRIDE = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_READ,
    SC_DRAIN,
    SC_DONE
  } scan_state_t;

  typedef struct packed {
    logic [KERNEL_BITS-1:0] k;
    logic [STRIDE_BITS-1:0] s;
    logic [DIM_BITS-1:0]    w;
    logic [DIM_BITS-1:0]    h;
  } cfg_t;

  typedef struct packed {
    logic                fire;
    logic [POS_BITS-1:0] r0;
    logic [POS_BITS-1:0] c0;
    logic [POS_BITS-1:0] wrow;
    logic [POS_BITS-1:0] wcol;
    logic                last;
  } win_t;

endpackage

FILE: hw/rtl/mp2a_ram.sv
module mp2a_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/mp2a_pos.sv
module mp2a_pos (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           frame_start,
  input  mp2a_pkg::cfg_t                 cfg,
  output logic [mp2a_pkg::ADDR_BITS-1:0] wr_addr,
  output mp2a_pkg::win_t                 win
);
  import mp2a_pkg::*;

  logic [POS_BITS-1:0]    in_row, in_row_next;
  logic [POS_BITS-1:0]    in_col, in_col_next;
  logic [POS_BITS-1:0]    window_row_count, window_row_count_next;
  logic [POS_BITS-1:0]    window_col_count, window_col_count_next;
  logic [STRIDE_BITS-1:0] row_phase, row_phase_next;
  logic [STRIDE_BITS-1:0] col_phase, col_phase_next;

  logic [POS_BITS-1:0]    row, col, wrc, wcc;
  logic [STRIDE_BITS-1:0] rp, cp;
  logic                   row_in, col_in, row_done, col_done;

  function automatic logic [STRIDE_BITS-1:0] step_phase(
    input logic [STRIDE_BITS-1:0] p,
    input logic [STRIDE_BITS-1:0] s
  );
    logic [STRIDE_BITS:0] inc;
    inc = {1'b0, p} + 1'b1;
    if (inc >= {1'b0, s}) begin
      return '0;
    end
    return inc[STRIDE_BITS-1:0];
  endfunction

  always_comb begin
    row = frame_start ? '0 : in_row;
    col = frame_start ? '0 : in_col;
    wrc = frame_start ? '0 : window_row_count;
    wcc = frame_start ? '0 : window_col_count;
    rp  = frame_start ? '0 : row_phase;
    cp  = frame_start ? '0 : col_phase;
    if ({1'b0, col} >= cfg.w) begin
      col = POS_BITS'(cfg.w - 1'b1);
    end
    if ({1'b0, row} >= cfg.h) begin
      row = POS_BITS'(cfg.h - 1'b1);
    end

    wr_addr = {row[SLOT_BITS-1:0], COL_BITS'(col)};

    row_in   = ({1'b0, row} + 1'b1) >= DIM_BITS'(cfg.k);
    col_in   = ({1'b0, col} + 1'b1) >= DIM_BITS'(cfg.k);
    row_done = row_in && (rp == '0);
    col_done = col_in && (cp == '0);

    win.fire = row_done && col_done;
    win.r0   = row - POS_BITS'(cfg.k - 1'b1);
    win.c0   = col - POS_BITS'(cfg.k - 1'b1);
    win.wrow = wrc;
    win.wcol = wcc;
    win.last = (({2'b0, row} + 10'(cfg.s)) >= 10'(cfg.h)) &&
               (({2'b0, col} + 10'(cfg.s)) >= 10'(cfg.w));

    window_col_count_next = wcc;
    col_phase_next        = cp;
    window_row_count_next = wrc;
    row_phase_next        = rp;
    in_row_next           = row;
    in_col_next           = col;

    if (col_in) begin
      if (win.fire) begin
        window_col_count_next = wcc + 1'b1;
      end
      col_phase_next = step_phase(cp, cfg.s);
    end

    if (({1'b0, col} + 1'b1) >= cfg.w) begin
      in_col_next           = '0;
      col_phase_next        = '0;
      window_col_count_next = '0;
      if (row_in) begin
        if (row_done) begin
          window_row_count_next = wrc + 1'b1;
        end
        row_phase_next = step_phase(rp, cfg.s);
      end
      if (({1'b0, row} + 1'b1) >= cfg.h) begin
        in_row_next           = '0;
        row_phase_next        = '0;
        window_row_count_next = '0;
      end else begin
        in_row_next = row + 1'b1;
      end
    end else begin
      in_col_next = col + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row           <= '0;
      in_col           <= '0;
      window_row_count <= '0;
      window_col_count <= '0;
      row_phase        <= '0;
      col_phase        <= '0;
    end else if (accept) begin
      in_row           <= in_row_next;
      in_col           <= in_col_next;
      window_row_count <= window_row_count_next;
      window_col_count <= window_col_count_next;
      row_phase        <= row_phase_next;
      col_phase        <= col_phase_next;
    end
  end

endmodule

FILE: hw/rtl/mp2a_scan.sv
module mp2a_scan (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  mp2a_pkg::win_t                        win,
  input  logic [mp2a_pkg::KERNEL_BITS-1:0]      k,
  output logic                                  busy,
  output logic                                  rd_en,
  output logic [mp2a_pkg::ADDR_BITS-1:0]        rd_addr,
  input  logic [mp2a_pkg::SAMPLE_BITS-1:0]      rd_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mp2a_pkg::SAMPLE_BITS-1:0] pooled_value,
  output logic [mp2a_pkg::POS_BITS-1:0]         out_row,
  output logic [mp2a_pkg::POS_BITS-1:0]         out_col,
  output logic [mp2a_pkg::POS_BITS-1:0]         max_row,
  output logic [mp2a_pkg::POS_BITS-1:0]         max_col,
  output logic                                  last
);
  import mp2a_pkg::*;

  scan_state_t state, state_next;

  logic [KIDX_BITS-1:0]          dr, dc, kmax;
  logic [POS_BITS-1:0]           r0, c0, wrow, wcol;
  logic                          win_last;
  logic                          rd_vld;
  logic [POS_BITS-1:0]           rd_row, rd_col, cur_row, cur_col;
  logic                          first;
  logic signed [SAMPLE_BITS-1:0] best;
  logic [POS_BITS-1:0]           br, bc;
  logic                          take, load;

  assign kmax    = KIDX_BITS'(k - 1'b1);
  assign cur_row = r0 + POS_BITS'(dr);
  assign cur_col = c0 + POS_BITS'(dc);
  assign rd_addr = {cur_row[SLOT_BITS-1:0], COL_BITS'(cur_col)};
  assign take    = rd_vld && (first || ($signed(rd_data) > best));

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    rd_en      = 1'b0;
    load       = 1'b0;
    case (state)
      SC_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = SC_READ;
        end
      end
      SC_READ: begin
        rd_en = 1'b1;
        if (dr == kmax && dc == kmax) begin
          state_next = SC_DRAIN;
        end
      end
      SC_DRAIN: begin
        state_next = SC_DONE;
      end
      SC_DONE: begin
        if (!out_valid || out_ready) begin
          load       = 1'b1;
          state_next = SC_IDLE;
        end
      end
      default: begin
        state_next = SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && state == SC_IDLE) begin
      r0       <= win.r0;
      c0       <= win.c0;
      wrow     <= win.wrow;
      wcol     <= win.wcol;
      win_last <= win.last;
      dr       <= '0;
      dc       <= '0;
      first    <= 1'b1;
    end else begin
      if (rd_en) begin
        rd_row <= cur_row;
        rd_col <= cur_col;
        if (dc == kmax) begin
          dc <= '0;
          dr <= dr + 1'b1;
        end else begin
          dc <= dc + 1'b1;
        end
      end
      if (take) begin
        best  <= $signed(rd_data);
        br    <= rd_row;
        bc    <= rd_col;
        first <= 1'b0;
      end
    end
    if (load) begin
      pooled_value <= best;
      out_row      <= wrow;
      out_col      <= wcol;
      max_row      <= br;
      max_col      <= bc;
      last         <= win_last;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == SC_IDLE)
    else $error("scan started while busy");

  a_done_seen: assert property (@(posedge clk) disable iff (rst)
    state == SC_DONE |-> !first)
    else $error("window finished with no sample compared");

  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == SC_DONE)
    else $error("result word raised outside the finish step");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == SC_READ |-> dr <= kmax && dc <= kmax)
    else $error("scan index beyond kernel");

endmodule

FILE: hw/rtl/max_pool_2d_argmax.sv
// A word that completes no window is taken and gives no result.
// A word that completes a window starts a scan: its k*k samples are read in turn,
// the last read drains, and the result loads once the previous result has been taken.
// One word per cycle between windows; no new word is taken while a window is scanned,
// as the single read port of the line store gives one window sample per cycle.
// Reset: counters clear, registers return to 2, 2, 256, 256; line store not cleared.
module max_pool_2d_argmax (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [1:0]                              cfg_index,
  input  logic [mp2a_pkg::CFG_BITS-1:0]           cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                    frame_start,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [mp2a_pkg::SAMPLE_BITS-1:0] pooled_value,
  output logic [mp2a_pkg::POS_BITS-1:0]           out_row,
  output logic [mp2a_pkg::POS_BITS-1:0]           out_col,
  output logic [mp2a_pkg::POS_BITS-1:0]           max_row,
  output logic [mp2a_pkg::POS_BITS-1:0]           max_col,
  output logic                                    last
);
  import mp2a_pkg::*;

  logic [KERNEL_BITS-1:0] win_side;
  logic [STRIDE_BITS-1:0] stride;
  logic [DIM_BITS-1:0]    image_width;
  logic [DIM_BITS-1:0]    image_height;

  cfg_t                   cfg;
  win_t                   win;
  logic                   accept, busy, rd_en;
  logic [ADDR_BITS-1:0]   wr_addr, rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_side     <= KERNEL_BITS'(2);
      stride       <= STRIDE_BITS'(2);
      image_width  <= DIM_BITS'(MAX_WIDTH);
      image_height <= DIM_BITS'(MAX_HEIGHT);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_KERNEL: win_side     <= cfg_data[KERNEL_BITS-1:0];
        REG_STRIDE: stride       <= cfg_data[STRIDE_BITS-1:0];
        REG_WIDTH:  image_width  <= cfg_data[DIM_BITS-1:0];
        REG_HEIGHT: image_height <= cfg_data[DIM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp registers to their usable ranges
  always_comb begin
    cfg.k = win_side;
    if (win_side == '0) begin
      cfg.k = KERNEL_BITS'(1);
    end else if (win_side > KERNEL_BITS'(MAX_KERNEL)) begin
      cfg.k = KERNEL_BITS'(MAX_KERNEL);
    end
    cfg.s = (stride == '0) ? STRIDE_BITS'(1) : stride;
    cfg.w = image_width;
    if (image_width == '0) begin
      cfg.w = DIM_BITS'(1);
    end else if (image_width > DIM_BITS'(MAX_WIDTH)) begin
      cfg.w = DIM_BITS'(MAX_WIDTH);
    end
    cfg.h = image_height;
    if (image_height == '0) begin
      cfg.h = DIM_BITS'(1);
    end else if (image_height > DIM_BITS'(MAX_HEIGHT)) begin
      cfg.h = DIM_BITS'(MAX_HEIGHT);
    end
  end

  mp2a_pos u_pos (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (frame_start),
    .cfg         (cfg),
    .wr_addr     (wr_addr),
    .win         (win)
  );

  mp2a_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (accept),
    .waddr (wr_addr),
    .wdata (sample),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mp2a_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .start        (accept && win.fire),
    .win          (win),
    .k            (cfg.k),
    .busy         (busy),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pooled_value (pooled_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .max_row      (max_row),
    .max_col      (max_col),
    .last         (last)
  );

endmodule

FILE: test/max_pool_2d_argmax_tb.sv
`timescale 1ns / 1ps

module max_pool_2d_argmax_tb;
  import mp2a_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [POS_BITS-1:0]           orow;
    logic [POS_BITS-1:0]           ocol;
    logic [POS_BITS-1:0]           mrow;
    logic [POS_BITS-1:0]           mcol;
    logic                          lst;
  } pool_res_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          fs;
    logic                          typed;
    logic                          gives;
    pool_res_t                     res;
  } dir_row_t;

  localparam int DIR_ROWS = 24;
  localparam int SETTLE_CYCLES = MAX_KERNEL * MAX_KERNEL + 16;
  localparam logic signed [SAMPLE_BITS-1:0] VMAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_BITS-1:0] VMIN = 16'sh8000;
  localparam pool_res_t NO_RES = '0;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [1:0]                    cfg_index;
  logic [CFG_BITS-1:0]           cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          frame_start;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [SAMPLE_BITS-1:0] pooled_value;
  logic [POS_BITS-1:0]           out_row;
  logic [POS_BITS-1:0]           out_col;
  logic [POS_BITS-1:0]           max_row;
  logic [POS_BITS-1:0]           max_col;
  logic                          last;

  max_pool_2d_argmax i_dut (.*);

  // shadow copy of the block
  logic [3:0]                    kern_reg;
  logic [3:0]                    strd_reg;
  logic [8:0]                    wid_reg;
  logic [8:0]                    hgt_reg;
  logic [POS_BITS-1:0]           pos_row;
  logic [POS_BITS-1:0]           pos_col;
  logic [POS_BITS-1:0]           win_row;
  logic [POS_BITS-1:0]           win_col;
  logic [3:0]                    ph_row;
  logic [3:0]                    ph_col;
  logic signed [SAMPLE_BITS-1:0] line_mem [STORE_DEPTH];

  pool_res_t window_q [$];
  int        send_idle;
  int        recv_stall;
  int        fail_count;
  int        words_sent;
  int        windows_seen;
  int        settings;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{16'sd1234, 1'b1, 1'b1, 1'b0, NO_RES},
    '{-16'sd1,   1'b0, 1'b1, 1'b0, NO_RES},
    '{VMAX,      1'b1, 1'b1, 1'b0, NO_RES},
    '{VMIN,      1'b0, 1'b1, 1'b0, NO_RES},
    '{VMIN,      1'b0, 1'b1, 1'b0, NO_RES},
    '{VMIN,      1'b0, 1'b1, 1'b0, NO_RES},
    '{16'sd5,    1'b0, 1'b1, 1'b0, NO_RES},
    '{VMAX,      1'b0, 1'b1, 1'b1, '{VMAX, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
    '{VMIN,      1'b0, 1'b1, 1'b0, NO_RES},
    '{VMIN,      1'b0, 1'b1, 1'b1, '{VMIN, 8'd0, 8'd1, 8'd0, 8'd2, 1'b0}},
    '{16'sd7,    1'b0, 1'b1, 1'b0, NO_RES},
    '{16'sd7,    1'b0, 1'b1, 1'b0, NO_RES},
    '{16'sd100,  1'b0, 1'b1, 1'b0, NO_RES},
    '{-16'sd5,   1'b0, 1'b1, 1'b0, NO_RES},
    '{16'sd7,    1'b0, 1'b1, 1'b0, NO_RES},
    '{16'sd9,    1'b0, 1'b1, 1'b1, '{16'sd9, 8'd1, 8'd0, 8'd3, 8'd1, 1'b0}},
    '{-16'sd5,   1'b0, 1'b1, 1'b0, NO_RES},
    '{16'sd100,  1'b0, 1'b1, 1'b1, '{16'sd100, 8'd1, 8'd1, 8'd2, 8'd2, 1'b1}},
    '{16'sh0001, 1'b0, 1'b0, 1'b0, NO_RES},
    '{16'shFFFE, 1'b0, 1'b0, 1'b0, NO_RES},
    '{16'sh5555, 1'b0, 1'b0, 1'b0, NO_RES},
    '{16'shAAAA, 1'b0, 1'b0, 1'b0, NO_RES},
    '{16'sd300,  1'b1, 1'b0, 1'b0, NO_RES},
    '{16'sh7FFE, 1'b0, 1'b0, 1'b0, NO_RES}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clampi(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [3:0] step_phase(input logic [3:0] p, input int s);
    return (int'(p) + 1 >= s) ? 4'd0 : p + 4'd1;
  endfunction

  task automatic pool_reset();
    kern_reg = 4'd2;
    strd_reg = 4'd2;
    wid_reg  = 9'd256;
    hgt_reg  = 9'd256;
    pos_row  = '0;
    pos_col  = '0;
    win_row  = '0;
    win_col  = '0;
    ph_row   = '0;
    ph_col   = '0;
    foreach (line_mem[j]) line_mem[j] = '0;
  endtask

  function automatic bit pool_step(input logic signed [SAMPLE_BITS-1:0] smp, input logic fs,
                                   output pool_res_t res);
    int k, s, w, h, r0, c0, br, bc;
    logic signed [SAMPLE_BITS-1:0] best, v;
    bit row_in, col_in, row_done, col_done, hit, first;
    k = clampi(int'(kern_reg), 1, MAX_KERNEL);
    s = clampi(int'(strd_reg), 1, 15);
    w = clampi(int'(wid_reg), 1, MAX_WIDTH);
    h = clampi(int'(hgt_reg), 1, MAX_HEIGHT);
    res = '0;
    if (fs) begin
      pos_row = '0;
      pos_col = '0;
      win_row = '0;
      win_col = '0;
      ph_row  = '0;
      ph_col  = '0;
    end
    if (int'(pos_col) >= w) pos_col = 8'(w - 1);
    if (int'(pos_row) >= h) pos_row = 8'(h - 1);
    line_mem[(int'(pos_row) % MAX_KERNEL) * MAX_WIDTH + int'(pos_col)] = smp;

    row_in   = int'(pos_row) + 1 >= k;
    col_in   = int'(pos_col) + 1 >= k;
    row_done = row_in && (ph_row == 4'd0);
    col_done = col_in && (ph_col == 4'd0);
    hit      = row_done && col_done;

    if (hit) begin
      r0    = int'(pos_row) + 1 - k;
      c0    = int'(pos_col) + 1 - k;
      best  = '0;
      br    = r0;
      bc    = c0;
      first = 1'b1;
      for (int dr = 0; dr < k; dr++) begin
        for (int dc = 0; dc < k; dc++) begin
          v = line_mem[((r0 + dr) % MAX_KERNEL) * MAX_WIDTH + c0 + dc];
          if (first || v > best) begin
            best  = v;
            br    = r0 + dr;
            bc    = c0 + dc;
            first = 1'b0;
          end
        end
      end
      res.value = best;
      res.orow  = win_row;
      res.ocol  = win_col;
      res.mrow  = 8'(br);
      res.mcol  = 8'(bc);
      res.lst   = (int'(pos_row) + s >= h) && (int'(pos_col) + s >= w);
    end

    if (col_in) begin
      if (hit) win_col = win_col + 8'd1;
      ph_col = step_phase(ph_col, s);
    end
    if (int'(pos_col) + 1 >= w) begin
      pos_col = '0;
      ph_col  = '0;
      win_col = '0;
      if (row_in) begin
        if (row_done) win_row = win_row + 8'd1;
        ph_row = step_phase(ph_row, s);
      end
      if (int'(pos_row) + 1 >= h) begin
        pos_row = '0;
        ph_row  = '0;
        win_row = '0;
      end else begin
        pos_row = pos_row + 8'd1;
      end
    end else begin
      pos_col = pos_col + 8'd1;
    end
    return hit;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    int pick;
    pick = int'($urandom_range(99));
    if (pick < 8) return VMAX;
    if (pick < 16) return VMIN;
    if (pick < 40) return 16'(int'($urandom_range(0, 6)) - 3);
    return 16'($urandom);
  endfunction

  task automatic send_word(input logic signed [SAMPLE_BITS-1:0] smp, input logic fs);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    sample      = smp;
    frame_start = fs;
    // hold the word until taken
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KERNEL: kern_reg = val[3:0];
      REG_STRIDE: strd_reg = val[3:0];
      REG_WIDTH:  wid_reg  = val;
      REG_HEIGHT: hgt_reg  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (window_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin : check_out
    pool_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (window_q.size() == 0) begin
        $error("window result with nothing expected");
        fail_count++;
      end else begin
        want = window_q.pop_front();
        windows_seen++;
        check_field("pooled_value", int'($signed(want.value)), int'($signed(pooled_value)));
        check_field("out_row", int'(want.orow), int'(out_row));
        check_field("out_col", int'(want.ocol), int'(out_col));
        check_field("max_row", int'(want.mrow), int'(max_row));
        check_field("max_col", int'(want.mcol), int'(max_col));
        check_field("last", int'(want.lst), int'(last));
      end
    end
  end

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int nitems, kv, sv, wv, hv, old_w;
    bit got, start_first;
    logic fs;
    logic signed [SAMPLE_BITS-1:0] smp;
    pool_res_t res;

    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = REG_KERNEL;
    cfg_data     = '0;
    in_valid     = 1'b0;
    sample       = '0;
    frame_start  = 1'b0;
    send_idle    = 0;
    recv_stall   = 0;
    fail_count   = 0;
    words_sent   = 0;
    windows_seen = 0;
    settings     = 1;
    pool_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == 2) begin
        settle();
        write_reg(REG_WIDTH, 9'd4);
        write_reg(REG_HEIGHT, 9'd4);
        settings++;
      end
      send_word(dir_tab[i].smp, dir_tab[i].fs);
      got = pool_step(dir_tab[i].smp, dir_tab[i].fs, res);
      if (dir_tab[i].typed) begin
        if (dir_tab[i].gives) window_q.push_back(dir_tab[i].res);
      end else if (got) begin
        window_q.push_back(res);
      end
    end

    for (int ph = 0; ph < 16; ph++) begin
      case (ph)
        0: begin kv = 1;  sv = 1;  wv = 300; hv = 1;   nitems = 258; end
        1: begin kv = 1;  sv = 1;  wv = 1;   hv = 300; nitems = 258; end
        2: begin kv = 0;  sv = 0;  wv = 0;   hv = 0;   nitems = 30;  end
        3: begin kv = 15; sv = 15; wv = 9;   hv = 8;   nitems = 80;  end
        4: begin kv = 5;  sv = 2;  wv = 3;   hv = 3;   nitems = 30;  end
        5: begin kv = 8;  sv = 1;  wv = 10;  hv = 9;   nitems = 90;  end
        6: begin kv = 2;  sv = 5;  wv = 12;  hv = 12;  nitems = 60;  end
        default: begin
          kv = ($urandom_range(9) == 0) ? int'($urandom_range(15)) : int'($urandom_range(1, 4));
          sv = ($urandom_range(9) == 0) ? int'($urandom_range(15)) : int'($urandom_range(1, 3));
          wv = int'($urandom_range(1, 14));
          hv = int'($urandom_range(1, 10));
          nitems = int'($urandom_range(12, 24));
        end
      endcase

      settle();
      old_w = clampi(int'(wid_reg), 1, MAX_WIDTH);
      write_reg(REG_KERNEL, {5'($urandom), 4'(kv)});
      write_reg(REG_STRIDE, {5'($urandom), 4'(sv)});
      write_reg(REG_WIDTH, 9'(wv));
      write_reg(REG_HEIGHT, 9'(hv));
      settings++;
      // a wider row would read columns never written in this frame
      start_first = (clampi(int'(wid_reg), 1, MAX_WIDTH) > old_w) || ($urandom_range(99) < 70);

      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 47; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 47; end
        default: begin send_idle = 22; recv_stall = 22; end
      endcase

      for (int n = 0; n < nitems; n++) begin
        if (n == 0) fs = start_first;
        else if (pos_row == 8'd0 && pos_col == 8'd0) fs = ($urandom_range(99) < 80);
        else fs = ($urandom_range(99) < 3);
        smp = rand_sample();
        send_word(smp, fs);
        if (pool_step(smp, fs, res)) window_q.push_back(res);
      end
    end

    settle();
    if (window_q.size() != 0) begin
      $error("%0d windows still outstanding", window_q.size());
      fail_count++;
    end
    $display("Summary: %0d samples sent, %0d windows checked, %0d register settings",
             words_sent, windows_seen, settings);
    $display("Covered kernels 1 to 8, strides 1 to 15, frames from 1x1 to 256 wide and tall");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: max_pool_2d_argmax.f
hw/rtl/mp2a_pkg.sv
hw/rtl/mp2a_ram.sv
hw/rtl/mp2a_pos.sv
hw/rtl/mp2a_scan.sv
hw/rtl/max_pool_2d_argmax.sv
test/max_pool_2d_argmax_tb.sv
